/* rtl/core/lcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

	// Default geometry width and queue depth.
	localparam int COORD_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 8;

	// Fixed field widths.
	localparam int FIELD_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int COUNT_W   = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_A_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_A_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_B_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_B_Y = 3'd3;

	// Reset values of the counting line.
	localparam logic [FIELD_W-1:0] LINE_A_X_RST = 16'd5600;
	localparam logic [FIELD_W-1:0] LINE_A_Y_RST = 16'd4480;
	localparam logic [FIELD_W-1:0] LINE_B_X_RST = 16'd16000;
	localparam logic [FIELD_W-1:0] LINE_B_Y_RST = 16'd4480;

	// One classified request as it moves from the geometry front to the counter.
	typedef struct packed {
		logic valid;
		logic hit;
	} lcc_item_t;

endpackage

`default_nettype wire

/* rtl/core/line_crossing_counter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted request passes the front pipeline registers, then the queue, then the output register.
// Throughput: one request per cycle while in_ready is high, bounded by QUEUE_DEPTH requests in flight between
// acceptance and the pop from the queue; the single output register in the back end, drained by out_ready, sets it.
// Reset: arst_n clears the count, the pipeline valid bits, the queue and the credit count,
// and loads the counting line with its default endpoints.

module line_crossing_counter_unit import lcc_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FIELD_W-1:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [FIELD_W-1:0]   start_x,
	input  wire logic [FIELD_W-1:0]   start_y,
	input  wire logic [FIELD_W-1:0]   end_x,
	input  wire logic [FIELD_W-1:0]   end_y,
	input  wire logic                 tracked,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      crossed,
	output logic [COUNT_W-1:0]        crossing_count
);

	localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);

	// Counting line endpoints, written through the configuration port.
	logic [FIELD_W-1:0] line_a_x_q, line_a_y_q, line_b_x_q, line_b_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_a_x_q <= LINE_A_X_RST;
			line_a_y_q <= LINE_A_Y_RST;
			line_b_x_q <= LINE_B_X_RST;
			line_b_y_q <= LINE_B_Y_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_A_X: line_a_x_q <= cfg_data;
				CFG_LINE_A_Y: line_a_y_q <= cfg_data;
				CFG_LINE_B_X: line_b_x_q <= cfg_data;
				CFG_LINE_B_Y: line_b_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front pipeline never stalls. Instead, a credit count tracks every request
	// between acceptance and its pop from the queue, so the queue always has room
	// for whatever the pipeline delivers, and the front only waits when the back
	// end and the output side have fallen QUEUE_DEPTH requests behind.
	logic              accept;
	logic              pop;
	logic [CRED_W-1:0] inflight_q;
	lcc_item_t         front_item;
	lcc_item_t         head;

	assign in_ready = (inflight_q < CRED_W'(QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CRED_W'(accept) - CRED_W'(pop);
		end
	end

	// Geometry front: differences, cross-product terms, their differences and the crossing test.
	lcc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.tracked (tracked),
		.line_a_x(line_a_x_q),
		.line_a_y(line_a_y_q),
		.line_b_x(line_b_x_q),
		.line_b_y(line_b_y_q),
		.item    (front_item)
	);

	// Short queue of crossing decisions between the two halves.
	lcc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_item(front_item),
		.pop      (pop),
		.head     (head)
	);

	// Back end: running count and output register.
	lcc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.crossed       (crossed),
		.crossing_count(crossing_count)
	);

endmodule

`default_nettype wire

/* rtl/core/lcc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcc_front import lcc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [FIELD_W-1:0] start_x,
	input  wire logic [FIELD_W-1:0] start_y,
	input  wire logic [FIELD_W-1:0] end_x,
	input  wire logic [FIELD_W-1:0] end_y,
	input  wire logic               tracked,
	input  wire logic [FIELD_W-1:0] line_a_x,
	input  wire logic [FIELD_W-1:0] line_a_y,
	input  wire logic [FIELD_W-1:0] line_b_x,
	input  wire logic [FIELD_W-1:0] line_b_y,
	output lcc_item_t               item
);

	localparam int W  = COORD_BITS + 1;
	localparam int PW = 2 * W;

	logic [COORD_BITS-1:0] sx, sy, ex, ey, ax, ay, bx, by;

	assign sx = COORD_BITS'(start_x);
	assign sy = COORD_BITS'(start_y);
	assign ex = COORD_BITS'(end_x);
	assign ey = COORD_BITS'(end_y);
	assign ax = COORD_BITS'(line_a_x);
	assign ay = COORD_BITS'(line_a_y);
	assign bx = COORD_BITS'(line_b_x);
	assign by = COORD_BITS'(line_b_y);

	logic v_s1, v_s2, v_s3, v_s4;
	logic trk_s1, trk_s2, trk_s3;
	logic signed [W-1:0] d1x_s1, d1y_s1, d2x_s1, d2y_s1;
	logic signed [W-1:0] sax_s1, say_s1, eax_s1, eay_s1;
	logic signed [PW-1:0] den_a_s2, den_b_s2, un_a_s2, un_b_s2;
	logic signed [PW-1:0] s0_a_s2, s0_b_s2, s1_a_s2, s1_b_s2;
	logic signed [PW-1:0] den_s3, unum_s3, side0_s3, side1_s3;
	logic hit_s4;
	logic in_box, opposite, hit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// Differences of zero-extended coordinates.
		trk_s1 <= tracked;
		d1x_s1 <= $signed({1'b0, ex}) - $signed({1'b0, sx});
		d1y_s1 <= $signed({1'b0, ey}) - $signed({1'b0, sy});
		d2x_s1 <= $signed({1'b0, bx}) - $signed({1'b0, ax});
		d2y_s1 <= $signed({1'b0, by}) - $signed({1'b0, ay});
		sax_s1 <= $signed({1'b0, sx}) - $signed({1'b0, ax});
		say_s1 <= $signed({1'b0, sy}) - $signed({1'b0, ay});
		eax_s1 <= $signed({1'b0, ex}) - $signed({1'b0, ax});
		eay_s1 <= $signed({1'b0, ey}) - $signed({1'b0, ay});

		// Partial products of the four cross products.
		trk_s2   <= trk_s1;
		den_a_s2 <= PW'(d2x_s1 * d1y_s1);
		den_b_s2 <= PW'(d2y_s1 * d1x_s1);
		un_a_s2  <= PW'(sax_s1 * d1y_s1);
		un_b_s2  <= PW'(say_s1 * d1x_s1);
		s0_a_s2  <= PW'(d2x_s1 * say_s1);
		s0_b_s2  <= PW'(d2y_s1 * sax_s1);
		s1_a_s2  <= PW'(d2x_s1 * eay_s1);
		s1_b_s2  <= PW'(d2y_s1 * eax_s1);

		// The differences cannot overflow PW bits.
		trk_s3   <= trk_s2;
		den_s3   <= den_a_s2 - den_b_s2;
		unum_s3  <= un_a_s2 - un_b_s2;
		side0_s3 <= s0_a_s2 - s0_b_s2;
		side1_s3 <= s1_a_s2 - s1_b_s2;

		hit_s4 <= hit_c;
	end

	// The line parameter u = unum / den lies in [0, 1]; the sign of den sets the
	// direction of the two compares, so no negation is needed.
	always_comb begin
		in_box = 1'b0;
		if (den_s3 > 0) begin
			in_box = (unum_s3 >= 0) && (unum_s3 <= den_s3);
		end else if (den_s3 < 0) begin
			in_box = (unum_s3 <= 0) && (unum_s3 >= den_s3);
		end
		opposite = ((side0_s3 > 0) && (side1_s3 < 0)) ||
			((side0_s3 < 0) && (side1_s3 > 0));
		hit_c = trk_s3 && in_box && opposite;
	end

	assign item.valid = v_s4;
	assign item.hit   = hit_s4;

endmodule

`default_nettype wire

/* rtl/core/lcc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcc_queue import lcc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire lcc_item_t push_item,
	input  wire logic      pop,
	output lcc_item_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DEPTH-1:0] mem_q;
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;

	// The credit count upstream keeps the queue from overflowing.
	assign push = push_item.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item.hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.hit   = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

/* rtl/core/lcc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcc_back import lcc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lcc_item_t          head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    crossed,
	output logic [COUNT_W-1:0]      crossing_count
);

	logic               out_valid_q;
	logic               crossed_q;
	logic [COUNT_W-1:0] count_q;

	// Take the next request whenever the output register is free or drains now.
	assign pop = head.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				count_q     <= count_q + COUNT_W'(head.hit);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			crossed_q <= head.hit;
		end
	end

	assign out_valid      = out_valid_q;
	assign crossed        = crossed_q;
	assign crossing_count = count_q;

endmodule

`default_nettype wire

/* rtl/core/lcc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lcc_checker import lcc_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic                 crossed,
	input wire logic [COUNT_W-1:0]   crossing_count
);

	// Count shown with the last delivered result.
	logic [COUNT_W-1:0] last_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (out_valid && out_ready) begin
			last_count_q <= crossing_count;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	a_hold_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(crossing_count) && $stable(crossed))
		else $error("stalled result changed");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crossed |-> crossing_count == last_count_q + 1'b1)
		else $error("crossing did not advance the count by one");

	a_count_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !crossed |-> crossing_count == last_count_q)
		else $error("count changed without a crossing");

endmodule

bind line_crossing_counter_unit lcc_checker u_lcc_checker (.*);

`default_nettype wire
